### hdl/zbh_pkg.sv
// ----------------------------------------------------------------------------
// zbh_pkg: shared definitions for the Zobrist board hash
// Field widths, default parameters, register map and the xorshift32 step.
// ----------------------------------------------------------------------------
package zbh_pkg;

  localparam int PIECE_KINDS_DEF = 12;
  localparam int SQUARES_DEF     = 64;

  localparam logic [31:0] SEED_RESET = 32'd1804289383;

  // non-board keys that follow the piece/square keys
  localparam int EP_KEYS       = 8;
  localparam int CASTLING_KEYS = 16;
  localparam int EXTRA_KEYS    = EP_KEYS + CASTLING_KEYS + 1;

  localparam int KIND_W   = 4;
  localparam int OCC_W    = 64;
  localparam int EP_W     = 7;
  localparam int CASTLE_W = 4;
  localparam int HASH_W   = 64;
  localparam int IN_W     = KIND_W + OCC_W + EP_W + CASTLE_W + 1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_PRNG_SEED = 1'b0;

  function automatic logic [31:0] xs_step(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

### hdl/zobrist_board_hash.sv
// ----------------------------------------------------------------------------
// zobrist_board_hash: Zobrist hash of chess positions
// Key table in one synchronous RAM, filled from an xorshift32 seed; bitboards
// are scanned one set square per cycle and their keys folded into the hash.
// ----------------------------------------------------------------------------
// Usage:
//   APB port: one register, prng_seed at byte address 0. A write refills the
//   key table; the table holds PIECE_KINDS*SQUARES+25 keys (793 at default
//   parameters), written one key per cycle. Reset starts the same fill with
//   the reset seed. s_tready stays low while the fill runs.
//   Input stream: one transfer per piece kind bitboard; s_tlast marks the
//   last bitboard of a position, whose ep/castling/side fields are used.
//   Output stream: one 64-bit hash per position, after the tlast transfer.
// Sequence:
//   An item is accepted in S_IDLE; S_SCAN then reads one key per set square
//   from the key RAM read port and returns to S_IDLE once the bitboard is
//   empty. The last item of a position goes on to S_EP, S_CASTLE and S_SIDE
//   for the ep, castling and side reads (the side key only when black is to
//   move), and S_DRAIN waits for the last key to land before m_tvalid is set.
//   The result sits in an output register; while it waits the next position
//   is taken in, and only the following tlast item stalls until it is taken.
// ----------------------------------------------------------------------------
module zobrist_board_hash #(
  parameter int PIECE_KINDS = zbh_pkg::PIECE_KINDS_DEF,
  parameter int SQUARES     = zbh_pkg::SQUARES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zbh_pkg::APB_AW-1:0] paddr,
  input  logic [zbh_pkg::APB_DW-1:0] pwdata,
  output logic [zbh_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // input: piece_kind[3:0], occupancy[67:4], ep_square[74:68],
  //        castling_mask[78:75], black_to_move[79]
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [zbh_pkg::IN_W-1:0]   s_tdata,
  input  logic                       s_tlast,   // last_of_position
  // output: position_hash[63:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [zbh_pkg::HASH_W-1:0] m_tdata
);

  localparam int BOARD_KEYS  = PIECE_KINDS * SQUARES;
  localparam int TABLE_SIZE  = BOARD_KEYS + zbh_pkg::EXTRA_KEYS;
  localparam int ADDR_W      = $clog2(TABLE_SIZE);
  localparam int SQ_W        = $clog2(SQUARES);
  localparam int EP_BASE     = BOARD_KEYS;
  localparam int CASTLE_BASE = EP_BASE + zbh_pkg::EP_KEYS;
  localparam int SIDE_IDX    = CASTLE_BASE + zbh_pkg::CASTLING_KEYS;

  typedef enum logic [6:0] {
    S_FILL   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_EP     = 7'b0001000,
    S_CASTLE = 7'b0010000,
    S_SIDE   = 7'b0100000,
    S_DRAIN  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0]                 prng_seed;
  logic [31:0]                 prng_state;
  logic [ADDR_W-1:0]           fill_idx;
  logic [zbh_pkg::HASH_W-1:0]  key_mem [TABLE_SIZE];
  logic [zbh_pkg::HASH_W-1:0]  key_q;
  logic                        key_vld;
  logic [zbh_pkg::HASH_W-1:0]  running_hash;

  logic [SQUARES-1:0]          occ;
  logic [ADDR_W-1:0]           kind_base;
  logic                        last_pos;
  logic                        ep_use;
  logic [2:0]                  ep_file;
  logic [zbh_pkg::CASTLE_W-1:0] castle;
  logic                        black;

  // input unpack
  logic [zbh_pkg::KIND_W-1:0]   in_kind;
  logic [zbh_pkg::OCC_W-1:0]    in_occ;
  logic [zbh_pkg::EP_W-1:0]     in_ep;
  logic [zbh_pkg::CASTLE_W-1:0] in_castle;
  logic                         in_black;

  assign in_kind   = s_tdata[3:0];
  assign in_occ    = s_tdata[67:4];
  assign in_ep     = s_tdata[74:68];
  assign in_castle = s_tdata[78:75];
  assign in_black  = s_tdata[79];

  logic in_xfer;
  logic cfg_wr;
  logic kind_ok;
  logic drain_go;
  logic fill_last;

  assign s_tready  = (state == S_IDLE);
  assign in_xfer   = s_tvalid && s_tready;
  assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == zbh_pkg::REG_PRNG_SEED);
  assign kind_ok   = ({1'b0, in_kind} < 5'(PIECE_KINDS));
  assign fill_last = (fill_idx == ADDR_W'(TABLE_SIZE - 1));
  assign drain_go  = (state == S_DRAIN) && !key_vld && (!m_tvalid || m_tready);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == zbh_pkg::REG_PRNG_SEED) ? prng_seed : '0;

  // key generation: four xorshift outputs per key, first in the low bits
  logic [31:0] xs1, xs2, xs3, xs4;
  logic [zbh_pkg::HASH_W-1:0] fill_key;

  always_comb begin
    xs1 = zbh_pkg::xs_step(prng_state);
    xs2 = zbh_pkg::xs_step(xs1);
    xs3 = zbh_pkg::xs_step(xs2);
    xs4 = zbh_pkg::xs_step(xs3);
    fill_key = {xs4[15:0], xs3[15:0], xs2[15:0], xs1[15:0]};
  end

  // lowest set square of the remaining bitboard
  logic [SQUARES-1:0] occ_low;
  logic [SQ_W-1:0]    sq_idx;

  always_comb begin
    occ_low = occ & (~occ + SQUARES'(1));
    sq_idx  = '0;
    for (int i = 0; i < SQUARES; i++) begin
      if (occ_low[i]) sq_idx = sq_idx | SQ_W'(i);
    end
  end

  // read port request
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      S_SCAN: begin
        rd_en   = (occ != '0);
        rd_addr = kind_base + ADDR_W'(sq_idx);
      end
      S_EP: begin
        rd_en   = ep_use;
        rd_addr = ADDR_W'(EP_BASE) + ADDR_W'(ep_file);
      end
      S_CASTLE: begin
        rd_en   = 1'b1;
        rd_addr = ADDR_W'(CASTLE_BASE) + ADDR_W'(castle);
      end
      S_SIDE: begin
        rd_en   = black;
        rd_addr = ADDR_W'(SIDE_IDX);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_FILL:   if (fill_last) state_next = S_IDLE;
      S_IDLE:   if (in_xfer) state_next = S_SCAN;
      S_SCAN:   if (occ == '0) state_next = last_pos ? S_EP : S_IDLE;
      S_EP:     state_next = S_CASTLE;
      S_CASTLE: state_next = S_SIDE;
      S_SIDE:   state_next = S_DRAIN;
      S_DRAIN:  if (drain_go) state_next = S_IDLE;
      default:  state_next = S_FILL;
    endcase
    if (cfg_wr) state_next = S_FILL;
  end

  // key RAM: fill writes and lookups never overlap, no forwarding needed
  always_ff @(posedge clk) begin
    if (state == S_FILL) key_mem[fill_idx] <= fill_key;
    if (rd_en) key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      prng_seed    <= zbh_pkg::SEED_RESET;
      prng_state   <= zbh_pkg::SEED_RESET;
      fill_idx     <= '0;
      key_vld      <= 1'b0;
      running_hash <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state   <= state_next;
      key_vld <= rd_en;

      if (cfg_wr) begin
        prng_seed  <= pwdata;
        prng_state <= pwdata;
        fill_idx   <= '0;
      end else if (state == S_FILL) begin
        prng_state <= xs4;
        fill_idx   <= fill_idx + ADDR_W'(1);
      end

      if (drain_go) running_hash <= '0;
      else if (key_vld) running_hash <= running_hash ^ key_q;

      if (drain_go) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_go) m_tdata <= running_hash;
    if (in_xfer) begin
      // an out-of-range kind scans an empty board
      occ       <= kind_ok ? in_occ[SQUARES-1:0] : '0;
      kind_base <= ADDR_W'(in_kind) * ADDR_W'(SQUARES);
      last_pos  <= s_tlast;
      ep_use    <= !in_ep[6];
      ep_file   <= in_ep[2:0];
      castle    <= in_castle;
      black     <= in_black;
    end else if (state == S_SCAN) begin
      occ <= occ & ~occ_low;
    end
  end

endmodule

### hdl/zbh_checker.sv
// ----------------------------------------------------------------------------
// zbh_checker: port-level checks for the Zobrist board hash
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module zbh_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [zbh_pkg::APB_AW-1:0] paddr,
  input logic                       pready,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [zbh_pkg::HASH_W-1:0] m_tdata
);

  logic seed_wr;
  assign seed_wr = psel && penable && pwrite && pready && (paddr[2] == zbh_pkg::REG_PRNG_SEED);

  // table fill follows reset
  a_reset_fill: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("block not busy and empty after reset");

  // a seed write restarts the fill
  a_seed_fill: assert property (@(posedge clk) disable iff (rst) seed_wr |=> !s_tready)
    else $error("input taken during table refill");

  // each bitboard is scanned before the next one is taken
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("back-to-back input transfers");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output changed while stalled");

endmodule

bind zobrist_board_hash zbh_checker u_zbh_checker (.*);

### tb/sv/zobrist_board_hash_test.sv
// ----------------------------------------------------------------------------
// zobrist_board_hash_test: self-checking bench for the Zobrist board hash
// Streams piece bitboards through the block with random gaps and back
// pressure, rebuilds the key table for each seed written over APB and checks
// every position hash against its own copy of the table and running hash.
// ----------------------------------------------------------------------------
module zobrist_board_hash_test;

  localparam int KIND_W   = zbh_pkg::KIND_W;
  localparam int OCC_W    = zbh_pkg::OCC_W;
  localparam int EP_W     = zbh_pkg::EP_W;
  localparam int CASTLE_W = zbh_pkg::CASTLE_W;
  localparam int IN_W     = zbh_pkg::IN_W;
  localparam int HASH_W   = zbh_pkg::HASH_W;
  localparam int APB_AW   = zbh_pkg::APB_AW;
  localparam int APB_DW   = zbh_pkg::APB_DW;

  localparam int NKINDS      = zbh_pkg::PIECE_KINDS_DEF;
  localparam int NSQ         = zbh_pkg::SQUARES_DEF;
  localparam int EP_BASE     = NKINDS * NSQ;
  localparam int CASTLE_BASE = EP_BASE + zbh_pkg::EP_KEYS;
  localparam int SIDE_IDX    = CASTLE_BASE + zbh_pkg::CASTLING_KEYS;
  localparam int NKEYS       = SIDE_IDX + 1;
  localparam int NO_EP       = 64;

  // s_tdata field offsets
  localparam int OCC_LSB = KIND_W;
  localparam int EP_LSB  = OCC_LSB + OCC_W;
  localparam int CAS_LSB = EP_LSB + EP_W;
  localparam int BLK_BIT = CAS_LSB + CASTLE_W;

  localparam logic [APB_AW-1:0] SEED_ADDR = APB_AW'(4 * int'(zbh_pkg::REG_PRNG_SEED));

  localparam int SETTLE_CYCLES  = 100;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic [OCC_W-1:0]    occ;
    logic [EP_W-1:0]     ep;
    logic [CASTLE_W-1:0] castle;
    logic                black;
    logic                last;
  } board_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata  = '0;
  logic              s_tlast  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [HASH_W-1:0] m_tdata;

  board_item_t       board_q[$];
  logic [HASH_W-1:0] hash_q[$];
  logic [63:0]       zkeys[NKEYS];
  logic [HASH_W-1:0] run_hash = '0;
  board_item_t       cur;

  int  pushed_cnt = 0;
  int  took_cnt   = 0;
  int  err_cnt    = 0;
  int  send_gap   = 0;
  int  stall_left = 0;
  int  idle_cyc   = 0;
  bit  no_idle    = 1'b0;
  bit  s_fire     = 1'b0;

  zobrist_board_hash dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // kind, occupancy, ep_square, castling_mask, black_to_move
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // position_hash
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // xorshift32, four 16-bit slices per key, low slice first
  task automatic build_keys(input logic [31:0] seed);
    logic [31:0] x;
    logic [63:0] k;
    x = seed;
    for (int i = 0; i < NKEYS; i++) begin
      k = '0;
      for (int p = 0; p < 4; p++) begin
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        k[16*p +: 16] = x[15:0];
      end
      zkeys[i] = k;
    end
  endtask

  task automatic fold_bitboard(input logic [IN_W-1:0] d, input logic lst);
    logic [KIND_W-1:0]   kind;
    logic [OCC_W-1:0]    occ;
    logic [EP_W-1:0]     ep;
    logic [CASTLE_W-1:0] castle;
    kind   = d[KIND_W-1:0];
    occ    = d[OCC_LSB +: OCC_W];
    ep     = d[EP_LSB +: EP_W];
    castle = d[CAS_LSB +: CASTLE_W];
    if (kind < NKINDS) begin
      for (int sq = 0; sq < NSQ; sq++)
        if (occ[sq]) run_hash ^= zkeys[int'(kind) * NSQ + sq];
    end
    if (lst) begin
      if (ep < NO_EP) run_hash ^= zkeys[EP_BASE + int'(ep[2:0])];
      run_hash ^= zkeys[CASTLE_BASE + int'(castle)];
      if (d[BLK_BIT]) run_hash ^= zkeys[SIDE_IDX];
      hash_q.push_back(run_hash);
      run_hash = '0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (no_idle || r < 50) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  function automatic logic [63:0] rand_board();
    int r;
    logic [63:0] b;
    r = int'($urandom_range(0, 99));
    b = '0;
    if (r < 55) begin
      repeat ($urandom_range(1, 4)) b[$urandom_range(0, 63)] = 1'b1;
    end else if (r < 75) begin
      b = {$urandom, $urandom};
    end else if (r < 85) begin
      b = '0;
    end else if (r < 97) begin
      b = {$urandom, $urandom} & {$urandom, $urandom};
    end else begin
      b = '1;
    end
    return b;
  endfunction

  function automatic int rand_ep();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 50) return NO_EP;
    if (r < 80) return int'($urandom_range(0, 63));
    return int'($urandom_range(NO_EP + 1, 127));
  endfunction

  task automatic add(input int kind, input logic [63:0] occ,
                     input int ep, input int castle, input int black, input int last);
    board_item_t it;
    it.kind   = KIND_W'(kind);
    it.occ    = occ;
    it.ep     = EP_W'(ep);
    it.castle = CASTLE_W'(castle);
    it.black  = (black != 0);
    it.last   = (last != 0);
    board_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic queue_position(input int n, input bit fin);
    int kind;
    for (int i = 0; i < n; i++) begin
      // now and then a kind beyond the piece set
      if ($urandom_range(0, 19) == 0) kind = int'($urandom_range(NKINDS, 15));
      else kind = int'($urandom_range(0, NKINDS - 1));
      add(kind, rand_board(), rand_ep(), int'($urandom_range(0, 15)),
          int'($urandom_range(0, 1)), int'(fin && (i == n - 1)));
    end
  endtask

  // fin = 0 leaves the phase inside an open position
  task automatic random_run(input int count, input bit fin);
    int done;
    int n;
    done = 0;
    while (done < count) begin
      n = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 3)) : int'($urandom_range(6, 12));
      queue_position(n, 1'b1);
      done += n;
    end
    if (!fin) queue_position(3, 1'b0);
  endtask

  // sender holds off until every hash is back and the block has gone quiet
  task automatic settle();
    do @(negedge clk); while (took_cnt != pushed_cnt || hash_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= seed;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    build_keys(seed);
  endtask

  // board driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !s_fire) begin
      // hold until the transfer completes
    end else if (send_gap > 0) begin
      s_tvalid <= 1'b0;
      send_gap--;
    end else if (board_q.size() > 0) begin
      cur = board_q.pop_front();
      s_tdata  <= {cur.black, cur.castle, cur.ep, cur.occ, cur.kind};
      s_tlast  <= cur.last;
      s_tvalid <= 1'b1;
      send_gap = pick_gap();
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // hash receiver back pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // monitor: predict on board transfers, check on hash transfers
  always @(posedge clk) begin
    s_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      took_cnt++;
      fold_bitboard(s_tdata, s_tlast);
    end
    if (!rst && m_tvalid && m_tready) begin
      if (hash_q.size() == 0) begin
        $error("position_hash: expected none, got %h", m_tdata);
        err_cnt++;
      end else if (m_tdata !== hash_q[0]) begin
        $error("position_hash: expected %h, got %h", hash_q[0], m_tdata);
        err_cnt++;
        void'(hash_q.pop_front());
      end else begin
        void'(hash_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("zobrist_board_hash: mismatch");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  initial begin
    build_keys(zbh_pkg::SEED_RESET);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed boards
    add(0, 64'h1, NO_EP, 0, 0, 1);
    add(11, '1, 0, 15, 1, 1);                          // full board, ep on file a
    add(12, 64'h0123_4567_89AB_CDEF, 10, 3, 1, 0);     // kind past the piece set
    add(15, '1, 127, 5, 0, 1);                         // ep above 64 means none
    add(3, 64'h8000_0000_0000_0001, 20, 9, 1, 0);      // tail fields ignored here
    add(5, 64'h0, NO_EP + 1, 0, 1, 1);
    add(1, 64'h0000_0000_0000_FF00, 63, 1, 0, 0);
    add(7, 64'h00FF_0000_0000_0000, 7, 2, 1, 1);
    add(6, 64'h8000_0000_0000_0000, 56, 14, 0, 1);
    add(2, 64'hAAAA_AAAA_AAAA_AAAA, NO_EP, 8, 1, 1);
    add(4, 64'h5555_5555_5555_5555, 40, 4, 0, 1);
    add(9, 64'h10, NO_EP, 0, 0, 0);                    // same square twice cancels
    add(9, 64'h10, NO_EP, 0, 0, 1);
    for (int k = 0; k < NKINDS; k++)
      add(k, rand_board(), 16 + k, 15, int'(k[0]), int'(k == NKINDS - 1));
    random_run(250, 1'b1);
    settle();

    write_seed(32'hFFFF_FFFF);
    random_run(150, 1'b0);
    settle();

    // seed change inside an open position keeps the running hash
    write_seed(32'd1);
    random_run(150, 1'b1);
    settle();

    // zero seed: every key is zero
    no_idle = 1'b1;
    write_seed(32'd0);
    random_run(60, 1'b1);
    settle();

    no_idle = 1'b0;
    write_seed($urandom);
    random_run(150, 1'b1);
    settle();

    write_seed(zbh_pkg::SEED_RESET);
    random_run(120, 1'b1);
    settle();

    if (err_cnt == 0) begin
      $display("zobrist_board_hash: match");
    end else begin
      $display("zobrist_board_hash: mismatch");
    end
    $finish;
  end

endmodule
